// ===== hw/rtl/stable_matching_engine_core_macros.svh =====
// Assertion helpers for the matching engine
`ifndef STABLE_MATCHING_ENGINE_CORE_MACROS_SVH
`define STABLE_MATCHING_ENGINE_CORE_MACROS_SVH
// implication checked every cycle outside reset
`define SME_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// implication checked in the cycle after the antecedent
`define SME_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== hw/rtl/sme_pkg.sv =====
// ----------------------------------------------------------------------------
// sme_pkg
// Shared types and constants of the stable matching engine.
// ----------------------------------------------------------------------------
`default_nettype none
package sme_pkg;
    localparam int MAX_PEOPLE = 32;
    localparam int IDW        = $clog2(MAX_PEOPLE);
    localparam int TAW        = 2 * IDW;
    localparam int TDEPTH     = MAX_PEOPLE * MAX_PEOPLE;

    localparam logic [1:0] ACT_LOAD_PROP = 2'd0;
    localparam logic [1:0] ACT_LOAD_ACC  = 2'd1;
    localparam logic [1:0] ACT_RUN       = 2'd2;

    typedef struct packed {
        logic [1:0] action;
        logic [6:0] person_id;
        logic [6:0] rank_position;
        logic [6:0] preferred_id;
    } t_req;

    typedef struct packed {
        logic [6:0]  acceptor_id;
        logic [6:0]  partner_id;
        logic        last;
        logic [12:0] proposer_rank_sum;
        logic [12:0] acceptor_rank_sum;
    } t_rsp;

    // table write request from the front end
    typedef struct packed {
        logic           prop_we;
        logic           acc_we;
        logic [TAW-1:0] addr;
        logic [6:0]     data;
    } t_tbl_wr;
endpackage
`default_nettype wire

// ===== hw/rtl/stable_matching_engine_core.sv =====
// Loads: a load request is written into the tables when accepted; the next may follow at once.
// A run: setup, then scan passes in which each proposal (at most n*n) reads a preference and may
// compare ranks, then the rank sums and n results at one per cycle while the output is taken.
// Throughput: one request at a time; the next is taken the cycle after the last result goes.
// Synchronous active-low reset clears control state and sets n to 32.
// ----------------------------------------------------------------------------
// stable_matching_engine_core
// Load preference tables, run Gale-Shapley matching, stream acceptor partners.
// ----------------------------------------------------------------------------
`default_nettype none
module stable_matching_engine_core
    import sme_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [6:0] i_cfg_data,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire t_req       i_req,
    output logic            o_valid,
    input  wire logic       i_ready,
    output t_rsp            o_rsp
);
    logic [6:0] r_people;
    logic       w_busy, w_acc, w_pok, w_pos_ok, w_pref_ok;
    t_tbl_wr    w_wr;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_people <= 7'd32;
        end else if (i_cfg_valid) begin
            r_people <= i_cfg_data;
        end
    end

    // engine owns the block during a run; loads are taken only while it is idle and no result is pending
    assign o_ready = !w_busy && !o_valid;
    assign w_acc   = i_valid && o_ready;

    assign w_pok     = i_req.person_id != 7'd0 && i_req.person_id <= 7'(MAX_PEOPLE);
    assign w_pos_ok  = i_req.rank_position != 7'd0 && i_req.rank_position <= 7'(MAX_PEOPLE);
    assign w_pref_ok = i_req.preferred_id != 7'd0 && i_req.preferred_id <= 7'(MAX_PEOPLE);

    always_comb begin
        w_wr         = '0;
        w_wr.prop_we = w_acc && i_req.action == ACT_LOAD_PROP && w_pok && w_pos_ok;
        w_wr.acc_we  = w_acc && i_req.action == ACT_LOAD_ACC && w_pok && w_pos_ok && w_pref_ok;
        if (i_req.action == ACT_LOAD_PROP) begin
            w_wr.addr = {IDW'(i_req.person_id - 7'd1), IDW'(i_req.rank_position - 7'd1)};
            w_wr.data = i_req.preferred_id;
        end else begin
            w_wr.addr = {IDW'(i_req.person_id - 7'd1), IDW'(i_req.preferred_id - 7'd1)};
            w_wr.data = i_req.rank_position;
        end
    end

    sme_engine u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wr(w_wr),
        .i_start(w_acc && i_req.action == ACT_RUN), .i_n(r_people),
        .o_busy(w_busy), .o_valid(o_valid), .o_rsp(o_rsp), .i_ready(i_ready));
endmodule
`default_nettype wire

// ===== hw/rtl/sme_ram.sv =====
// ----------------------------------------------------------------------------
// sme_ram
// Single write, single read synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module sme_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 7
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/sme_engine.sv =====
// ----------------------------------------------------------------------------
// sme_engine
// Gale-Shapley sequencer over the preference memories and state arrays.
// ----------------------------------------------------------------------------
`default_nettype none
`include "stable_matching_engine_core_macros.svh"
module sme_engine
    import sme_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_tbl_wr    i_wr,
    input  wire logic       i_start,
    input  wire logic [6:0] i_n,
    output logic            o_busy,
    output logic            o_valid,
    output t_rsp            o_rsp,
    input  wire logic       i_ready
);
    typedef enum logic [3:0] {
        S_IDLE, S_CLR, S_SCAN, S_PREF, S_RANK1, S_RANK2, S_SUMP, S_SUMA, S_SUMA2, S_EMIT
    } t_state;

    t_state          r_state;
    logic [IDW:0]    r_n;
    logic [IDW:0]    r_p;        // current proposer, 0-based, IDW+1 bits to hold n
    logic [IDW:0]    r_a;
    logic [IDW:0]    r_pos [MAX_PEOPLE];
    logic [6:0]      r_part [MAX_PEOPLE];
    logic            r_match [MAX_PEOPLE];
    logic            r_changed;
    logic [6:0]      r_tgt;      // acceptor 1-based under proposal
    logic [6:0]      r_cur;      // her current partner, 1-based
    logic [7:0]      r_rnew;
    logic [12:0]     r_psum, r_asum;

    logic [TAW-1:0]  n_praddr, n_araddr;
    logic [6:0]      w_pref, w_rank;
    logic [IDW-1:0]  w_pi, w_ti, w_ci, w_ai;
    logic [7:0]      w_reff;

    assign w_pi = r_p[IDW-1:0];
    assign w_ai = r_a[IDW-1:0];
    assign w_ti = IDW'(r_tgt - 7'd1);
    assign w_ci = IDW'(r_cur - 7'd1);
    assign w_reff = (w_rank == 7'd0) ? 8'd255 : {1'b0, w_rank};

    sme_ram #(.DEPTH(TDEPTH), .WIDTH(7)) u_pref (
        .i_clk(i_clk), .i_we(i_wr.prop_we), .i_waddr(i_wr.addr), .i_wdata(i_wr.data),
        .i_raddr(n_praddr), .o_rdata(w_pref));
    sme_ram #(.DEPTH(TDEPTH), .WIDTH(7)) u_rank (
        .i_clk(i_clk), .i_we(i_wr.acc_we), .i_waddr(i_wr.addr), .i_wdata(i_wr.data),
        .i_raddr(n_araddr), .o_rdata(w_rank));

    // read addresses, issued one state ahead of use
    always_comb begin
        n_praddr = {w_pi, r_pos[w_pi][IDW-1:0]};
        n_araddr = {w_ti, w_pi};
        case (r_state)
            S_PREF:  n_araddr = {IDW'(w_pref - 7'd1), w_pi};
            S_RANK1: n_araddr = {w_ti, w_ci};
            S_SUMP, S_SUMA: n_araddr = {w_ai, IDW'(r_part[w_ai] - 7'd1)};
            default: ;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_n     <= (i_n == 7'd0) ? (IDW+1)'(1)
                                 : (i_n > 7'(MAX_PEOPLE)) ? (IDW+1)'(MAX_PEOPLE)
                                 : (IDW+1)'(i_n);
                        r_state <= S_CLR;
                    end
                end
                S_CLR: begin
                    for (int i = 0; i < MAX_PEOPLE; i++) begin
                        r_pos[i]   <= '0;
                        r_part[i]  <= '0;
                        r_match[i] <= 1'b0;
                    end
                    r_p       <= '0;
                    r_a       <= '0;
                    r_changed <= 1'b0;
                    r_psum    <= '0;
                    r_asum    <= '0;
                    r_state   <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_p == r_n) begin
                        r_p       <= '0;
                        r_changed <= 1'b0;
                        r_state   <= r_changed ? S_SCAN : S_SUMP;
                    end else if (!r_match[w_pi] && r_pos[w_pi] < r_n) begin
                        r_changed <= 1'b1;
                        r_state   <= S_PREF;
                    end else begin
                        r_p <= r_p + 1'b1;
                    end
                end
                S_PREF: begin
                    if (w_pref == 7'd0 || w_pref > 7'(r_n)) begin
                        r_pos[w_pi] <= r_pos[w_pi] + 1'b1;
                        r_state     <= S_SCAN;
                    end else if (r_part[IDW'(w_pref - 7'd1)] == 7'd0) begin
                        r_part[IDW'(w_pref - 7'd1)] <= 7'(r_p) + 7'd1;
                        r_match[w_pi] <= 1'b1;
                        r_state       <= S_SCAN;
                    end else begin
                        r_tgt   <= w_pref;
                        r_cur   <= r_part[IDW'(w_pref - 7'd1)];
                        r_state <= S_RANK1;
                    end
                end
                S_RANK1: begin
                    r_rnew  <= w_reff;
                    r_state <= S_RANK2;
                end
                S_RANK2: begin
                    if (r_rnew < w_reff) begin
                        r_match[w_ci] <= 1'b0;
                        r_pos[w_ci]   <= r_pos[w_ci] + 1'b1;
                        r_part[w_ti]  <= 7'(r_p) + 7'd1;
                        r_match[w_pi] <= 1'b1;
                    end else begin
                        r_pos[w_pi] <= r_pos[w_pi] + 1'b1;
                    end
                    r_state <= S_SCAN;
                end
                S_SUMP: begin
                    if (r_a == r_n) begin
                        r_a     <= '0;
                        r_state <= S_SUMA;
                    end else begin
                        if (r_match[w_ai]) begin
                            r_psum <= r_psum + 13'(r_pos[w_ai]) + 13'd1;
                        end
                        r_a <= r_a + 1'b1;
                    end
                end
                S_SUMA: begin
                    r_state <= S_SUMA2;
                end
                S_SUMA2: begin
                    if (r_part[w_ai] != 7'd0) begin
                        r_asum <= r_asum + 13'(w_rank);
                    end
                    if (r_a + 1'b1 == r_n) begin
                        r_a     <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_a     <= r_a + 1'b1;
                        r_state <= S_SUMA;
                    end
                end
                S_EMIT: begin
                    if (!o_valid || i_ready) begin
                        if (o_valid && r_a == r_n) begin
                            o_valid <= 1'b0;
                            r_a     <= '0;
                            r_state <= S_IDLE;
                        end else if (r_a == r_n) begin
                            r_a     <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            o_valid                 <= 1'b1;
                            o_rsp.acceptor_id       <= 7'(r_a) + 7'd1;
                            o_rsp.partner_id        <= r_part[w_ai];
                            o_rsp.last              <= (r_a + 1'b1 == r_n);
                            o_rsp.proposer_rank_sum <= (r_a + 1'b1 == r_n) ? r_psum : 13'd0;
                            o_rsp.acceptor_rank_sum <= (r_a + 1'b1 == r_n) ? r_asum : 13'd0;
                            r_a                     <= r_a + 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (r_state == S_IDLE && o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    `SME_ASSERT_IMP(a_pos_bound, i_clk, i_rst_n, r_state == S_PREF, r_pos[w_pi] < r_n, "proposal past list end")
    `SME_ASSERT_NXT(a_clr_scan, i_clk, i_rst_n, r_state == S_CLR, r_state == S_SCAN, "clear did not enter scan")
    `SME_ASSERT_IMP(a_emit_ok, i_clk, i_rst_n, o_valid && o_rsp.last, o_rsp.acceptor_id == 7'(r_n), "last on wrong acceptor")
endmodule
`default_nettype wire

// ===== tb/sme_checker.sv =====
// ----------------------------------------------------------------------------
// sme_checker
// Watches the request, config and result channels of the matching engine,
// runs its own Gale-Shapley predictor on every accepted run request and
// compares each result with the oldest expected partner record.
// ----------------------------------------------------------------------------
module sme_checker
    import sme_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [6:0] i_cfg_data,
    input  logic       i_valid,
    input  logic       i_ready,
    input  t_req       i_req,
    input  logic       i_rsp_valid,
    input  logic       i_rsp_ready,
    input  t_rsp       i_rsp,
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [6:0] pref_list [MAX_PEOPLE][MAX_PEOPLE];
    logic [6:0] rank_of   [MAX_PEOPLE][MAX_PEOPLE];
    logic [6:0] people_n;
    t_rsp       partner_queue [$];

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    function automatic int eff_rank(int a, int p);
        return (rank_of[a][p] == 0) ? 255 : int'(rank_of[a][p]);
    endfunction

    task automatic predict_matching();
        int   n;
        int   next_pos [MAX_PEOPLE];
        int   partner  [MAX_PEOPLE];
        bit   engaged  [MAX_PEOPLE];
        bit   changed;
        int   a1, a, cur, psum, asum;
        t_rsp r;
        n = (people_n == 0) ? 1 : (people_n > MAX_PEOPLE) ? MAX_PEOPLE : int'(people_n);
        foreach (next_pos[i]) begin
            next_pos[i] = 0;
            partner[i] = 0;
            engaged[i] = 0;
        end
        do begin
            changed = 0;
            for (int p = 0; p < n; p++) begin
                while (!engaged[p] && next_pos[p] < n) begin
                    a1 = pref_list[p][next_pos[p]];
                    changed = 1;
                    if (a1 == 0 || a1 > n) begin
                        next_pos[p]++;
                        continue;
                    end
                    a = a1 - 1;
                    cur = partner[a];
                    if (cur == 0) begin
                        partner[a] = p + 1;
                        engaged[p] = 1;
                    end else if (eff_rank(a, p) < eff_rank(a, cur - 1)) begin
                        engaged[cur - 1] = 0;
                        next_pos[cur - 1]++;
                        partner[a] = p + 1;
                        engaged[p] = 1;
                    end else begin
                        next_pos[p]++;
                    end
                end
            end
        end while (changed);
        psum = 0;
        asum = 0;
        for (int p = 0; p < n; p++)
            if (engaged[p]) psum += next_pos[p] + 1;
        for (int i = 0; i < n; i++)
            if (partner[i] != 0) asum += rank_of[i][partner[i] - 1];
        for (int i = 0; i < n; i++) begin
            r.acceptor_id = 7'(i + 1);
            r.partner_id = 7'(partner[i]);
            r.last = (i + 1 == n);
            r.proposer_rank_sum = r.last ? 13'(psum) : '0;
            r.acceptor_rank_sum = r.last ? 13'(asum) : '0;
            partner_queue.push_back(r);
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            people_n <= 7'd32;
        end else begin
            if (i_cfg_valid && i_cfg_ready) people_n <= i_cfg_data;
            if (i_valid && i_ready) begin
                if (i_req.person_id >= 1 && i_req.person_id <= MAX_PEOPLE &&
                    i_req.rank_position >= 1 && i_req.rank_position <= MAX_PEOPLE) begin
                    if (i_req.action == ACT_LOAD_PROP)
                        pref_list[i_req.person_id - 1][i_req.rank_position - 1] =
                            i_req.preferred_id;
                    else if (i_req.action == ACT_LOAD_ACC && i_req.preferred_id >= 1 &&
                             i_req.preferred_id <= MAX_PEOPLE)
                        rank_of[i_req.person_id - 1][i_req.preferred_id - 1] =
                            i_req.rank_position;
                end
                if (i_req.action == ACT_RUN) predict_matching();
            end
            if (i_rsp_valid && i_rsp_ready) begin
                if (partner_queue.size() == 0) begin
                    report_mismatch("unexpected result, acceptor", i_rsp.acceptor_id, 0);
                end else begin
                    want = partner_queue.pop_front();
                    if (i_rsp.acceptor_id !== want.acceptor_id)
                        report_mismatch("acceptor_id", i_rsp.acceptor_id, want.acceptor_id);
                    if (i_rsp.partner_id !== want.partner_id)
                        report_mismatch("partner_id", i_rsp.partner_id, want.partner_id);
                    if (i_rsp.last !== want.last)
                        report_mismatch("last", i_rsp.last, want.last);
                    if (i_rsp.proposer_rank_sum !== want.proposer_rank_sum)
                        report_mismatch("proposer_rank_sum", i_rsp.proposer_rank_sum,
                                        want.proposer_rank_sum);
                    if (i_rsp.acceptor_rank_sum !== want.acceptor_rank_sum)
                        report_mismatch("acceptor_rank_sum", i_rsp.acceptor_rank_sum,
                                        want.acceptor_rank_sum);
                end
            end
        end
        o_pending = partner_queue.size();
    end
endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives the matching engine with full preference loads, runs, noise loads
// and config changes under random stalls; sme_checker scores the results.
// ----------------------------------------------------------------------------
module tb_top;
    import sme_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic       i_clk = 0;
    logic       i_rst_n = 0;
    logic       cfg_valid = 0;
    logic       cfg_ready;
    logic [6:0] cfg_data = '0;
    logic       req_valid = 0;
    logic       req_ready;
    t_req       req = '0;
    logic       rsp_valid;
    logic       rsp_ready = 0;
    t_rsp       rsp;
    int         fail_count;
    int         pending;

    // idle-burst controls
    bit         calm = 0;       // last part of the run: no idling
    bit         hold_rsp = 0;   // long receiver hold-off
    int         items_sent = 0;

    always #5 i_clk = ~i_clk;

    stable_matching_engine_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .i_valid(req_valid), .o_ready(req_ready), .i_req(req),
        .o_valid(rsp_valid), .i_ready(rsp_ready), .o_rsp(rsp)
    );

    sme_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .i_valid(req_valid), .i_ready(req_ready), .i_req(req),
        .i_rsp_valid(rsp_valid), .i_rsp_ready(rsp_ready), .i_rsp(rsp),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver: random stall bursts; hold_rsp forces a long hold-off
    initial begin
        int burst;
        forever begin
            @(posedge i_clk);
            if (hold_rsp) begin
                rsp_ready <= 0;
                repeat (300) @(posedge i_clk);
                hold_rsp = 0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                burst = $urandom_range(1, 6);
                rsp_ready <= 0;
                repeat (burst - 1) @(posedge i_clk);
            end else begin
                rsp_ready <= 1;
            end
        end
    end

    // one request; valid stays high across back-to-back requests
    task automatic send_request(input logic [1:0] act, input int who, input int pos,
                                input int pref);
        req_valid <= 1;
        req.action <= act;
        req.person_id <= 7'(who);
        req.rank_position <= 7'(pos);
        req.preferred_id <= 7'(pref);
        do @(posedge i_clk); while (!req_ready);
        items_sent++;
        // sender idle burst
        if (!calm && $urandom_range(0, 4) == 0) begin
            req_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        req_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        // pad with idle time after the last result is back
        repeat (4 * 32 * 32 + 200) @(posedge i_clk);
    endtask

    task automatic write_people(input int n);
        cfg_valid <= 1;
        cfg_data <= 7'(n);
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 0;
    endtask

    // full well-formed tables for people 1..n; lists are random permutations
    // of 1..n, with an optional bad proposer entry or ignored acceptor load mixed in
    task automatic load_tables(input int n, input bit noisy);
        int perm [MAX_PEOPLE];
        int j, t;
        for (int s = 0; s < 2; s++)
            for (int p = 1; p <= n; p++) begin
                for (int i = 0; i < n; i++) perm[i] = i + 1;
                for (int i = n - 1; i > 0; i--) begin
                    j = $urandom_range(0, i);
                    t = perm[i]; perm[i] = perm[j]; perm[j] = t;
                end
                for (int i = 0; i < n; i++) begin
                    t = perm[i];
                    if (noisy && $urandom_range(0, 9) == 0)
                        t = (s == 0) ? $urandom_range(0, 127) : perm[i];
                    if (s == 0) begin
                        send_request(ACT_LOAD_PROP, p, i + 1, t);
                    end else begin
                        if (noisy && $urandom_range(0, 9) == 0)
                            send_request(ACT_LOAD_ACC, p, 0, t);  // ignored load
                        send_request(ACT_LOAD_ACC, p, i + 1, t);
                    end
                end
            end
    endtask

    initial begin
        int n;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: everyone's first choice is distinct, so full-size runs
        // need only first entries; then extremes of n
        for (int p = 1; p <= MAX_PEOPLE; p++) begin
            send_request(ACT_LOAD_PROP, p, 1, p);
            send_request(ACT_LOAD_ACC, p, 1, p);
        end
        send_request(ACT_RUN, 0, 0, 0);
        // out-of-range and unknown-action requests; no effect
        send_request(ACT_LOAD_PROP, 0, 1, 127);
        send_request(ACT_LOAD_PROP, 127, 127, 127);
        send_request(ACT_LOAD_ACC, 5, 127, 3);
        send_request(ACT_LOAD_ACC, 5, 3, 0);
        send_request(ACT_LOAD_ACC, 5, 3, 127);
        send_request(2'd3, 127, 127, 127);
        send_request(ACT_RUN, 0, 0, 0);
        // long receiver hold-off while the sender keeps going
        wait_drained();
        write_people(1);
        hold_rsp = 1;
        for (int k = 0; k < 6; k++) send_request(ACT_RUN, 85, 42, 85);
        wait_drained();
        write_people(0);           // acts as one
        send_request(ACT_RUN, 0, 0, 0);
        wait_drained();
        write_people(127);         // clamps to MAX_PEOPLE
        send_request(ACT_RUN, 0, 0, 0);
        // sender pauses until every result is back
        wait_drained();
        write_people(2);
        send_request(ACT_RUN, 0, 0, 0);

        // random phases: mostly small n, some larger, some noise
        while (items_sent < 500) begin
            wait_drained();
            if (items_sent > 400) calm = 1;
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 10) : $urandom_range(2, 6);
            write_people(n);
            load_tables(n, $urandom_range(0, 2) == 0);
            repeat ($urandom_range(0, 3))
                send_request(2'($urandom_range(0, 3)), $urandom_range(0, 127),
                             $urandom_range(0, 127), $urandom_range(0, 127));
            send_request(ACT_RUN, $urandom_range(0, 127), $urandom_range(0, 127),
                         $urandom_range(0, 127));
            if ($urandom_range(0, 1)) send_request(ACT_RUN, 0, 0, 0);
        end
        wait_drained();
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #60ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
